### hw/rtl/flash_dword_write_packer_defines.svh
// assertion macros for the flash double-word write packer
// every macro samples on clk and is disabled while rst_n is low
`ifndef FLASH_DWORD_WRITE_PACKER_DEFINES_SVH
`define FLASH_DWORD_WRITE_PACKER_DEFINES_SVH

// overlapping implication, consequent checked in the same cycle
`define FDWP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// non-overlapping implication, consequent checked in the cycle after
`define FDWP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/fdwp_pkg.sv
`default_nettype none

package fdwp_pkg;

    // flash size as log2 of its byte count
    localparam int FLASH_BYTES_LOG2 = 19;

    localparam int LANES     = 8;
    localparam int LANE_BITS = $clog2(LANES);
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = 19;
    localparam int INDEX_W   = 16;
    localparam int DWORD_W   = LANES * BYTE_W;

    // double-word index bits that fit the flash, capped at the port width
    localparam int INDEX_BITS =
        (FLASH_BYTES_LOG2 - LANE_BITS < INDEX_W) ? FLASH_BYTES_LOG2 - LANE_BITS : INDEX_W;
    localparam logic [INDEX_W-1:0] INDEX_MASK = INDEX_W'((64'd1 << INDEX_BITS) - 64'd1);

    localparam logic [DWORD_W-1:0] ERASED_WORD = '1;
    localparam logic [LANE_BITS-1:0] LAST_LANE = LANE_BITS'(LANES - 1);

    typedef struct packed {
        logic [BYTE_W-1:0] byte_value;
        logic              first_of_run;
        logic              last_of_run;
        logic [ADDR_W-1:0] dest_byte_address;
    } byte_item_t;

    // held byte transaction as seen by the packing stage
    typedef struct packed {
        logic       valid;
        byte_item_t item;
    } byte_stage_t;

endpackage

`default_nettype wire

### hw/rtl/fdwp_byte_if.sv
`default_nettype none

interface fdwp_byte_if
    import fdwp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;
    logic              first_of_run;
    logic              last_of_run;
    logic [ADDR_W-1:0] dest_byte_address;

    modport source (
        output valid,
        input  ready,
        output byte_value,
        output first_of_run,
        output last_of_run,
        output dest_byte_address
    );

    modport sink (
        input  valid,
        output ready,
        input  byte_value,
        input  first_of_run,
        input  last_of_run,
        input  dest_byte_address
    );
endinterface

`default_nettype wire

### hw/rtl/fdwp_dword_if.sv
`default_nettype none

interface fdwp_dword_if
    import fdwp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [INDEX_W-1:0] dword_address;
    logic [DWORD_W-1:0] dword_data;
    logic               run_done;

    modport source (
        output valid,
        input  ready,
        output dword_address,
        output dword_data,
        output run_done
    );

    modport sink (
        input  valid,
        output ready,
        input  dword_address,
        input  dword_data,
        input  run_done
    );
endinterface

`default_nettype wire

### hw/rtl/fdwp_in_reg.sv
`default_nettype none

module fdwp_in_reg
    import fdwp_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire byte_item_t  in_item,
    input  wire logic        advance,
    output byte_stage_t      stage
);

    logic       valid_reg;
    logic       valid_next;
    byte_item_t item_reg;

    // free when empty or when the held byte moves on this cycle
    assign in_ready = !valid_reg || advance;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    // control flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

    assign stage.valid = valid_reg;
    assign stage.item  = item_reg;

endmodule

`default_nettype wire

### hw/rtl/fdwp_pack.sv
`default_nettype none

module fdwp_pack
    import fdwp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire byte_stage_t  stage,
    output logic              advance,
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [INDEX_W-1:0] dword_address,
    output logic [DWORD_W-1:0] dword_data,
    output logic              run_done
);

    logic [DWORD_W-1:0]   word_reg;
    logic [DWORD_W-1:0]   word_next;
    logic [LANE_BITS-1:0] lane_reg;
    logic [LANE_BITS-1:0] lane_next;
    logic [INDEX_W-1:0]   index_reg;
    logic [INDEX_W-1:0]   index_next;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [INDEX_W-1:0]   addr_reg;
    logic [DWORD_W-1:0]   data_reg;
    logic                 done_reg;

    logic [DWORD_W-1:0]   base_word;
    logic [DWORD_W-1:0]   filled_word;
    logic [LANE_BITS-1:0] lane;
    logic [INDEX_W-1:0]   index;
    logic                 emit;

    // start of run restarts lane, index and word
    always_comb
    begin
        if (stage.item.first_of_run)
        begin
            lane      = stage.item.dest_byte_address[LANE_BITS-1:0];
            index     = INDEX_W'(stage.item.dest_byte_address >> LANE_BITS) & INDEX_MASK;
            base_word = ERASED_WORD;
        end
        else
        begin
            lane      = lane_reg;
            index     = index_reg;
            base_word = word_reg;
        end
    end

    // drop the byte into its lane
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            filled_word[i*BYTE_W +: BYTE_W] = (lane == LANE_BITS'(i)) ?
                stage.item.byte_value : base_word[i*BYTE_W +: BYTE_W];
        end
    end

    assign emit    = (lane == LAST_LANE) || stage.item.last_of_run;
    assign advance = stage.valid && (!emit || !out_valid_reg || out_ready);

    // next packing state
    always_comb
    begin
        word_next      = word_reg;
        lane_next      = lane_reg;
        index_next     = index_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (advance)
        begin
            if (emit)
            begin
                word_next      = ERASED_WORD;
                lane_next      = '0;
                index_next     = (index + INDEX_W'(1)) & INDEX_MASK;
                out_valid_next = 1'b1;
            end
            else
            begin
                word_next  = filled_word;
                lane_next  = lane + LANE_BITS'(1);
                index_next = index;
            end
        end
    end

    // packing state and output flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_reg      <= ERASED_WORD;
            lane_reg      <= '0;
            index_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            word_reg      <= word_next;
            lane_reg      <= lane_next;
            index_reg     <= index_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            addr_reg <= index;
            data_reg <= filled_word;
            done_reg <= stage.item.last_of_run;
        end
    end

    assign out_valid     = out_valid_reg;
    assign dword_address = addr_reg;
    assign dword_data    = data_reg;
    assign run_done      = done_reg;

endmodule

`default_nettype wire

### hw/rtl/flash_dword_write_packer.sv
// flash double-word write packer
//
// byte_in takes one data byte per transaction; the byte flagged first_of_run
// carries the flash byte offset, whose low three bits pick the starting lane.
// dword_out gives one aligned 64-bit double word per transaction, little-endian,
// with its double-word index; lanes not written by the run read 0xFF.
// a double word goes out when lane 7 fills or on the byte flagged last_of_run,
// and run_done marks the one holding that last byte.
// a byte that closes a word is first held in the input register, and its double
// word is loaded into the result register when that byte moves on.
// throughput: one byte per cycle while results are taken, set by the single
// packing stage between the input register and the result register.
// a stalled receiver holds the result; bytes that do not close a word are still
// taken, and one that closes a word waits in the input register until the
// result is taken.
// reset empties both registers, sets the assembly word to all ones and starts
// packing at lane 0 of double word 0.
`default_nettype none

module flash_dword_write_packer
    import fdwp_pkg::*;
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    fdwp_byte_if.sink   byte_in,
    fdwp_dword_if.source dword_out
);

    byte_item_t  in_item;
    byte_stage_t stage;
    logic        advance;

    // gather the byte fields
    assign in_item.byte_value        = byte_in.byte_value;
    assign in_item.first_of_run      = byte_in.first_of_run;
    assign in_item.last_of_run       = byte_in.last_of_run;
    assign in_item.dest_byte_address = byte_in.dest_byte_address;

    // input register
    fdwp_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (byte_in.valid),
        .in_ready (byte_in.ready),
        .in_item  (in_item),
        .advance  (advance),
        .stage    (stage)
    );

    // packing stage and result register
    fdwp_pack u_pack (
        .clk           (clk),
        .rst_n         (rst_n),
        .stage         (stage),
        .advance       (advance),
        .out_valid     (dword_out.valid),
        .out_ready     (dword_out.ready),
        .dword_address (dword_out.dword_address),
        .dword_data    (dword_out.dword_data),
        .run_done      (dword_out.run_done)
    );

endmodule

`default_nettype wire

### hw/rtl/fdwp_checker.sv
`default_nettype none
`include "flash_dword_write_packer_defines.svh"

module fdwp_checker
    import fdwp_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               in_valid,
    input wire logic               in_ready,
    input wire logic               out_valid,
    input wire logic               out_ready,
    input wire logic [INDEX_W-1:0] dword_address,
    input wire logic [DWORD_W-1:0] dword_data,
    input wire logic               run_done
);

    logic in_accept;
    logic out_stall;

    assign in_accept = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    // a stalled result stays offered
    `FDWP_ASSERT_NEXT(a_out_hold, out_stall, out_valid, "result dropped while stalled")

    // a stalled result keeps its payload
    `FDWP_ASSERT_NEXT(a_out_stable, out_stall,
        $stable(dword_address) && $stable(dword_data) && $stable(run_done),
        "result changed while stalled")

    // a fresh result comes from an earlier byte transaction
    `FDWP_ASSERT_SAME(a_out_from_byte, $rose(out_valid), $past(in_accept, 2),
        "result appeared without a byte transaction")

endmodule

bind flash_dword_write_packer fdwp_checker u_fdwp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (byte_in.valid),
    .in_ready      (byte_in.ready),
    .out_valid     (dword_out.valid),
    .out_ready     (dword_out.ready),
    .dword_address (dword_out.dword_address),
    .dword_data    (dword_out.dword_data),
    .run_done      (dword_out.run_done)
);

`default_nettype wire

### verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import fdwp_pkg::*;

    localparam int STALL_LIMIT  = 3000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 12;
    localparam int RANDOM_BYTES = 1330;

    typedef struct packed {
        logic [INDEX_W-1:0] dword_address;
        logic [DWORD_W-1:0] dword_data;
        logic               run_done;
    } dword_result_t;

    // one byte transaction, with a hand-written result where it is obvious
    typedef struct packed {
        byte_item_t    item;
        logic          typed;
        dword_result_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    fdwp_byte_if  byte_bus ();
    fdwp_dword_if dword_bus ();

    flash_dword_write_packer uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_bus),
        .dword_out (dword_bus)
    );

    // packing state mirrored by the predictor
    logic [DWORD_W-1:0]   fill_word  = ERASED_WORD;
    logic [LANE_BITS-1:0] fill_lane  = '0;
    logic [INDEX_W-1:0]   fill_index = '0;

    stim_row_t     offered_rows[$];
    dword_result_t expected_dwords[$];
    int            bytes_taken   = 0;
    int            stalled_cycles = 0;
    int            mismatches    = 0;
    bit            hold_done     = 1'b0;

    // directed rows: reset lane, address extremes, full and split words, restarts, wrap
    stim_row_t directed_rows [23] = '{
        '{'{8'h00, 1'b0, 1'b1, 19'h00000}, 1'b1, '{16'h0000, 64'hFFFF_FFFF_FFFF_FF00, 1'b1}},
        '{'{8'hA5, 1'b1, 1'b1, 19'h7FFFF}, 1'b1, '{16'hFFFF, 64'hA5FF_FFFF_FFFF_FFFF, 1'b1}},
        '{'{8'h5A, 1'b1, 1'b1, 19'h00003}, 1'b1, '{16'h0000, 64'hFFFF_FFFF_5AFF_FFFF, 1'b1}},
        '{'{8'h01, 1'b1, 1'b0, 19'h00040}, 1'b0, '0},
        '{'{8'h02, 1'b0, 1'b0, 19'h2AAAA}, 1'b0, '0},
        '{'{8'h03, 1'b0, 1'b0, 19'h55555}, 1'b0, '0},
        '{'{8'h04, 1'b0, 1'b0, 19'h7FFFF}, 1'b0, '0},
        '{'{8'h05, 1'b0, 1'b0, 19'h00000}, 1'b0, '0},
        '{'{8'h06, 1'b0, 1'b0, 19'h2AAAA}, 1'b0, '0},
        '{'{8'h07, 1'b0, 1'b0, 19'h55555}, 1'b0, '0},
        '{'{8'h08, 1'b0, 1'b1, 19'h7FFFF}, 1'b1, '{16'h0008, 64'h0807_0605_0403_0201, 1'b1}},
        '{'{8'hC0, 1'b1, 1'b0, 19'h0000D}, 1'b0, '0},
        '{'{8'hC1, 1'b0, 1'b0, 19'h00000}, 1'b0, '0},
        '{'{8'hC2, 1'b0, 1'b0, 19'h00000}, 1'b0, '0},
        '{'{8'hC3, 1'b0, 1'b0, 19'h00000}, 1'b0, '0},
        '{'{8'hC4, 1'b0, 1'b1, 19'h00000}, 1'b0, '0},
        '{'{8'h11, 1'b1, 1'b0, 19'h00100}, 1'b0, '0},
        '{'{8'h22, 1'b0, 1'b0, 19'h00000}, 1'b0, '0},
        '{'{8'h33, 1'b1, 1'b1, 19'h00021}, 1'b1, '{16'h0004, 64'hFFFF_FFFF_FFFF_33FF, 1'b1}},
        '{'{8'hFF, 1'b0, 1'b1, 19'h00000}, 1'b1, '{16'h0005, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1}},
        '{'{8'h00, 1'b1, 1'b0, 19'h7FFFE}, 1'b0, '0},
        '{'{8'hFF, 1'b0, 1'b0, 19'h00000}, 1'b1, '{16'hFFFF, 64'hFF00_FFFF_FFFF_FFFF, 1'b0}},
        '{'{8'h80, 1'b0, 1'b1, 19'h00000}, 1'b1, '{16'h0000, 64'hFFFF_FFFF_FFFF_FF80, 1'b1}}
    };

    // clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // predictor: places one byte, returns 1 when a double word goes out
    function automatic bit pack_into_dword(input byte_item_t it, output dword_result_t res);
        logic [ADDR_W-1:0] offset;
        bit                emitted;
        if (it.first_of_run)
        begin
            offset     = it.dest_byte_address & ADDR_W'((64'd1 << FLASH_BYTES_LOG2) - 64'd1);
            fill_lane  = offset[LANE_BITS-1:0];
            fill_index = INDEX_W'(offset >> LANE_BITS) & INDEX_MASK;
            fill_word  = ERASED_WORD;
        end
        fill_word[fill_lane*BYTE_W +: BYTE_W] = it.byte_value;
        emitted = (fill_lane == LAST_LANE) || it.last_of_run;
        res = '{fill_index, fill_word, it.last_of_run};
        if (emitted)
        begin
            fill_word  = ERASED_WORD;
            fill_lane  = '0;
            fill_index = (fill_index + 1'b1) & INDEX_MASK;
        end
        else
        begin
            fill_lane = fill_lane + 1'b1;
        end
        return emitted;
    endfunction

    // stretch of the run where neither side idles
    function automatic bit in_steady_stretch();
        return bytes_taken >= 800 && bytes_taken < 1050;
    endfunction

    // offer one byte transaction, with an occasional idle gap first
    task automatic offer_byte(input stim_row_t row);
        if (!in_steady_stretch() && $urandom_range(99) < 27)
        begin
            byte_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        offered_rows.push_back(row);
        byte_bus.valid             <= 1'b1;
        byte_bus.byte_value        <= row.item.byte_value;
        byte_bus.first_of_run      <= row.item.first_of_run;
        byte_bus.last_of_run       <= row.item.last_of_run;
        byte_bus.dest_byte_address <= row.item.dest_byte_address;
        do
            @(posedge clk);
        while (!byte_bus.ready);
    endtask

    // one run of random bytes, closed with last_of_run when asked
    task automatic offer_run(input int run_len, input logic [ADDR_W-1:0] start,
                             input bit closed, inout int sent);
        stim_row_t row;
        for (int k = 0; k < run_len; k++)
        begin
            row = '0;
            row.item.byte_value        = BYTE_W'($urandom);
            row.item.first_of_run      = (k == 0);
            row.item.last_of_run       = closed && (k == run_len - 1);
            row.item.dest_byte_address = (k == 0) ? start : ADDR_W'($urandom);
            offer_byte(row);
            sent++;
        end
    endtask

    // result receiver, with one long hold-off to back the block up
    initial
    begin
        dword_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!hold_done && bytes_taken >= 450)
            begin
                hold_done = 1'b1;
                dword_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            dword_bus.ready <= in_steady_stretch() || ($urandom_range(99) >= 27);
        end
    end

    // checking of output transactions and prediction of input ones
    always @(posedge clk)
    begin
        dword_result_t got;
        dword_result_t want;
        dword_result_t predicted;
        stim_row_t     row;
        byte_item_t    taken;
        if (rst_n)
        begin
            if (dword_bus.valid && dword_bus.ready)
            begin
                got = '{dword_bus.dword_address, dword_bus.dword_data, dword_bus.run_done};
                if (expected_dwords.size() == 0)
                begin
                    $error("unexpected double word at address %h, data %h",
                           got.dword_address, got.dword_data);
                    mismatches++;
                end
                else
                begin
                    want = expected_dwords.pop_front();
                    if (got.dword_address !== want.dword_address)
                    begin
                        $error("dword_address: expected %h, got %h",
                               want.dword_address, got.dword_address);
                        mismatches++;
                    end
                    if (got.dword_data !== want.dword_data)
                    begin
                        $error("dword_data: expected %h, got %h",
                               want.dword_data, got.dword_data);
                        mismatches++;
                    end
                    if (got.run_done !== want.run_done)
                    begin
                        $error("run_done: expected %b, got %b", want.run_done, got.run_done);
                        mismatches++;
                    end
                end
            end
            if (byte_bus.valid && byte_bus.ready)
            begin
                taken = '{byte_bus.byte_value, byte_bus.first_of_run,
                          byte_bus.last_of_run, byte_bus.dest_byte_address};
                row = (offered_rows.size() != 0) ? offered_rows.pop_front() : '0;
                if (pack_into_dword(taken, predicted))
                    expected_dwords.push_back(row.typed ? row.want : predicted);
                bytes_taken <= bytes_taken + 1;
            end
        end
    end

    // watchdog on cycles with no transaction on either side
    always @(posedge clk)
    begin
        if ((byte_bus.valid && byte_bus.ready) || (dword_bus.valid && dword_bus.ready))
        begin
            stalled_cycles <= 0;
        end
        else
        begin
            stalled_cycles <= stalled_cycles + 1;
            if (stalled_cycles == STALL_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // reset, directed rows, random runs, drain
    initial
    begin
        int                sent;
        int                pick;
        int                run_len;
        logic [ADDR_W-1:0] start;
        stim_row_t         noise;
        sent = 0;
        rst_n                      <= 1'b0;
        byte_bus.valid             <= 1'b0;
        byte_bus.byte_value        <= '0;
        byte_bus.first_of_run      <= 1'b0;
        byte_bus.last_of_run       <= 1'b0;
        byte_bus.dest_byte_address <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_byte(directed_rows[i]);

        // mostly well-formed runs, some left open, some lone noise bytes
        while (sent < RANDOM_BYTES)
        begin
            pick = $urandom_range(99);
            if ($urandom_range(9) == 0)
                start = {16'hFFFF, LANE_BITS'($urandom)};
            else
                start = ADDR_W'($urandom);
            if (pick < 75)
            begin
                run_len = ($urandom_range(99) < 85) ? $urandom_range(1, 16)
                                                    : $urandom_range(17, 40);
                offer_run(run_len, start, 1'b1, sent);
            end
            else if (pick < 87)
            begin
                offer_run($urandom_range(1, 12), start, 1'b0, sent);
            end
            else
            begin
                noise = '0;
                noise.item = byte_item_t'($bits(byte_item_t)'($urandom));
                noise.item.dest_byte_address = start;
                offer_byte(noise);
                sent++;
            end
        end
        byte_bus.valid <= 1'b0;
        @(posedge clk);

        while (expected_dwords.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
